/* rtl/csvt_pkg.sv */
// Shared types and constants of the CSV field tokenizer.
package csvt_pkg;

    typedef enum logic [1:0] {
        MODE_TEXT  = 2'd0,
        MODE_CHUNK = 2'd1,
        MODE_EOI   = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CLS_QUOTE = 3'd0,
        CLS_COMMA = 3'd1,
        CLS_EOL   = 3'd2,
        CLS_OTHER = 3'd3,
        CLS_CHUNK = 3'd4,
        CLS_EOI   = 3'd5
    } class_t;

    typedef struct packed {
        class_t     cls;
        logic [7:0] data;
    } token_t;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_DATA  = 3'd1,
        PH_QUOTE = 3'd2,
        PH_SKIP  = 3'd3,
        PH_ERROR = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int QUEUE_DEPTH = 2;

endpackage

/* rtl/csv_field_tokenizer.sv */
// Top level of the CSV field tokenizer.
//
//   Channel   Handshake           Payload
//   input     s_valid / s_ready   s_mode, s_data_byte
//   result    m_valid / m_ready   m_kind, m_char_out, m_field_index,
//                                 m_record_end, m_too_many_fields
//
// One input word per cycle is sustained while the result channel is not stalled;
// a word's result passes through a queue slot, then the output register.
// The parser state machine updates once per word popped from the queue.
// Reset is synchronous on aresetn and clears the queue, parser state and
// output valid. A stalled result holds in the output register while the
// two-entry queue keeps accepting words until it fills.
module csv_field_tokenizer #(
    parameter int MAX_FIELDS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_char_out,
    output logic [4:0]  m_field_index,
    output logic        m_record_end,
    output logic        m_too_many_fields
);

    logic             push;
    logic             pop;
    logic             queue_full;
    logic             queue_empty;
    csvt_pkg::token_t push_token;
    csvt_pkg::token_t head_token;

    csvt_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_data_byte (s_data_byte),
        .queue_full  (queue_full),
        .push        (push),
        .push_token  (push_token)
    );

    csvt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_token (push_token),
        .full       (queue_full),
        .pop        (pop),
        .head_token (head_token),
        .empty      (queue_empty)
    );

    csvt_back #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .queue_empty       (queue_empty),
        .head_token        (head_token),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_char_out        (m_char_out),
        .m_field_index     (m_field_index),
        .m_record_end      (m_record_end),
        .m_too_many_fields (m_too_many_fields)
    );

endmodule

/* rtl/csvt_front.sv */
// Front end: accepts input words and classifies them into tokens.
module csvt_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic [7:0]          s_data_byte,
    input  logic                queue_full,
    output logic                push,
    output csvt_pkg::token_t    push_token
);

    always_comb begin
        push_token.data = s_data_byte;
        push_token.cls  = csvt_pkg::CLS_OTHER;
        unique case (s_mode)
            csvt_pkg::MODE_TEXT: begin
                unique case (s_data_byte) inside
                    csvt_pkg::CH_QUOTE:            push_token.cls = csvt_pkg::CLS_QUOTE;
                    csvt_pkg::CH_COMMA:            push_token.cls = csvt_pkg::CLS_COMMA;
                    csvt_pkg::CH_CR, csvt_pkg::CH_LF: push_token.cls = csvt_pkg::CLS_EOL;
                    default:                       push_token.cls = csvt_pkg::CLS_OTHER;
                endcase
            end
            csvt_pkg::MODE_CHUNK: push_token.cls = csvt_pkg::CLS_CHUNK;
            csvt_pkg::MODE_EOI:   push_token.cls = csvt_pkg::CLS_EOI;
            default:              push_token.cls = csvt_pkg::CLS_OTHER;
        endcase
    end

    // An unused mode is accepted and dropped here.
    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full && (s_mode != csvt_pkg::MODE_NONE);

endmodule

/* rtl/csvt_queue.sv */
// Two-entry token queue between the front and back ends.
module csvt_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  csvt_pkg::token_t    push_token,
    output logic                full,
    input  logic                pop,
    output csvt_pkg::token_t    head_token,
    output logic                empty
);

    csvt_pkg::token_t slot_reg [csvt_pkg::QUEUE_DEPTH];
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full       = (count_reg == 2'd2);
    assign empty      = (count_reg == 2'd0);
    assign head_token = slot_reg[0];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && pop) begin
            if (count_reg == 2'd1) begin
                slot_reg[0] <= push_token;
            end else begin
                slot_reg[0] <= slot_reg[1];
                slot_reg[1] <= push_token;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                slot_reg[0] <= push_token;
            end else begin
                slot_reg[1] <= push_token;
            end
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
        end
    end

endmodule

/* rtl/csvt_back.sv */
// Back end: parser state machine and result output register.
module csvt_back #(
    parameter int MAX_FIELDS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                queue_empty,
    input  csvt_pkg::token_t    head_token,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [7:0]          m_char_out,
    output logic [4:0]          m_field_index,
    output logic                m_record_end,
    output logic                m_too_many_fields
);

    localparam int CW = $clog2(MAX_FIELDS);
    localparam int XW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] LAST_INDEX = CW'(MAX_FIELDS - 1);

    csvt_pkg::phase_t phase_reg, phase_next;
    logic             quoted_reg, quoted_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;

    logic             res;
    csvt_pkg::kind_t  res_kind;
    logic [7:0]       res_char;
    logic             res_rec;
    logic             end_req;
    logic             end_rec;
    logic             end_skip;
    logic             clear_req;
    logic [XW-1:0]    index_ext;

    logic             out_valid_reg;
    logic [1:0]       kind_reg;
    logic [7:0]       char_reg;
    logic [4:0]       index_reg;
    logic             rec_reg;
    logic             ovf_out_reg;

    assign pop       = !queue_empty && (!out_valid_reg || m_ready);
    assign index_ext = XW'(cnt_reg);

    always_comb begin
        phase_next  = phase_reg;
        quoted_next = quoted_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        res         = 1'b0;
        res_kind    = csvt_pkg::KIND_DATA;
        res_char    = 8'd0;
        res_rec     = 1'b0;
        end_req     = 1'b0;
        end_rec     = 1'b0;
        end_skip    = 1'b0;
        clear_req   = 1'b0;

        unique case (phase_reg)
            csvt_pkg::PH_START: begin
                case (head_token.cls)
                    csvt_pkg::CLS_QUOTE: begin
                        quoted_next = 1'b1;
                        phase_next  = csvt_pkg::PH_DATA;
                    end
                    csvt_pkg::CLS_COMMA: begin
                        end_req = 1'b1;
                    end
                    csvt_pkg::CLS_EOL: begin
                        end_req  = 1'b1;
                        end_rec  = 1'b1;
                        end_skip = 1'b1;
                    end
                    csvt_pkg::CLS_CHUNK: begin
                        end_req = 1'b1;
                        end_rec = 1'b1;
                    end
                    csvt_pkg::CLS_EOI: begin
                        end_req   = (cnt_reg != '0) || ovf_reg;
                        end_rec   = 1'b1;
                        clear_req = 1'b1;
                    end
                    default: begin
                        quoted_next = 1'b0;
                        phase_next  = csvt_pkg::PH_DATA;
                        res         = 1'b1;
                        res_char    = head_token.data;
                    end
                endcase
            end
            csvt_pkg::PH_DATA: begin
                case (head_token.cls)
                    csvt_pkg::CLS_QUOTE: begin
                        if (quoted_reg) begin
                            phase_next = csvt_pkg::PH_QUOTE;
                        end else begin
                            res      = 1'b1;
                            res_char = head_token.data;
                        end
                    end
                    csvt_pkg::CLS_COMMA: begin
                        if (quoted_reg) begin
                            res      = 1'b1;
                            res_char = head_token.data;
                        end else begin
                            end_req = 1'b1;
                        end
                    end
                    csvt_pkg::CLS_EOL: begin
                        if (quoted_reg) begin
                            res      = 1'b1;
                            res_char = head_token.data;
                        end else begin
                            end_req  = 1'b1;
                            end_rec  = 1'b1;
                            end_skip = 1'b1;
                        end
                    end
                    csvt_pkg::CLS_CHUNK: begin
                        end_req = !quoted_reg;
                        end_rec = 1'b1;
                    end
                    csvt_pkg::CLS_EOI: begin
                        if (quoted_reg) begin
                            res      = 1'b1;
                            res_kind = csvt_pkg::KIND_ERROR;
                        end else begin
                            end_req = 1'b1;
                            end_rec = 1'b1;
                        end
                        clear_req = 1'b1;
                    end
                    default: begin
                        res      = 1'b1;
                        res_char = head_token.data;
                    end
                endcase
            end
            csvt_pkg::PH_QUOTE: begin
                case (head_token.cls)
                    csvt_pkg::CLS_QUOTE: begin
                        phase_next = csvt_pkg::PH_DATA;
                        res        = 1'b1;
                        res_char   = head_token.data;
                    end
                    csvt_pkg::CLS_COMMA: begin
                        end_req = 1'b1;
                    end
                    csvt_pkg::CLS_EOL: begin
                        end_req  = 1'b1;
                        end_rec  = 1'b1;
                        end_skip = 1'b1;
                    end
                    csvt_pkg::CLS_CHUNK: begin
                        end_req = 1'b1;
                        end_rec = 1'b1;
                    end
                    csvt_pkg::CLS_EOI: begin
                        end_req   = 1'b1;
                        end_rec   = 1'b1;
                        clear_req = 1'b1;
                    end
                    default: begin
                        phase_next = csvt_pkg::PH_ERROR;
                        res        = 1'b1;
                        res_kind   = csvt_pkg::KIND_ERROR;
                    end
                endcase
            end
            csvt_pkg::PH_SKIP: begin
                clear_req = (head_token.cls == csvt_pkg::CLS_CHUNK) ||
                            (head_token.cls == csvt_pkg::CLS_EOI);
            end
            default: begin
                clear_req = (head_token.cls == csvt_pkg::CLS_EOI);
            end
        endcase

        if (end_req) begin
            res      = 1'b1;
            res_kind = csvt_pkg::KIND_END;
            res_rec  = end_rec;
            quoted_next = 1'b0;
            if (end_rec) begin
                cnt_next   = '0;
                ovf_next   = 1'b0;
                phase_next = end_skip ? csvt_pkg::PH_SKIP : csvt_pkg::PH_START;
            end else begin
                if (cnt_reg == LAST_INDEX) begin
                    ovf_next = 1'b1;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
                phase_next = csvt_pkg::PH_START;
            end
        end

        if (clear_req) begin
            phase_next  = csvt_pkg::PH_START;
            quoted_next = 1'b0;
            cnt_next    = '0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= csvt_pkg::PH_START;
            quoted_reg <= 1'b0;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
        end else if (pop) begin
            phase_reg  <= phase_next;
            quoted_reg <= quoted_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= res;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && res) begin
            kind_reg    <= res_kind;
            char_reg    <= res_char;
            index_reg   <= index_ext[4:0];
            rec_reg     <= res_rec;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_kind            = kind_reg;
    assign m_char_out        = char_reg;
    assign m_field_index     = index_reg;
    assign m_record_end      = rec_reg;
    assign m_too_many_fields = ovf_out_reg;

endmodule

/* tb/sv/csv_field_tokenizer_test.sv */
// Self-checking testbench of the CSV field tokenizer with a scoreboard and random CSV traffic.
`timescale 1ns / 1ps

module csv_field_tokenizer_test;

    localparam int MAX_FIELDS   = 32;
    localparam int WORD_TARGET  = 1300;
    localparam int CALM_START   = 1150;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [2:0] {
        TOK_START,
        TOK_DATA,
        TOK_QUOTE,
        TOK_DELIM,
        TOK_SKIP,
        TOK_ERROR
    } tok_phase_t;

    typedef struct {
        csvt_pkg::kind_t kind;
        logic [7:0]      ch;
        logic [4:0]      index;
        logic            rec_end;
        logic            overflow;
    } token_result_t;

    class csv_token_board;
        token_result_t expected_q[$];
        int unsigned   mismatches;
        tok_phase_t    phase;
        bit            quoted;
        int unsigned   field_no;
        bit            overflow;

        function new();
            mismatches = 0;
            clear_record();
        endfunction

        function void clear_record();
            phase    = TOK_START;
            quoted   = 1'b0;
            field_no = 0;
            overflow = 1'b0;
        endfunction

        function void emit(csvt_pkg::kind_t kind, logic [7:0] ch, bit rec_end);
            token_result_t r;
            r.kind     = kind;
            r.ch       = ch;
            r.index    = field_no[4:0];
            r.rec_end  = rec_end;
            r.overflow = overflow;
            expected_q.push_back(r);
        endfunction

        function void close_field(bit rec_end, bit skip_rest);
            emit(csvt_pkg::KIND_END, 8'h00, rec_end);
            if (rec_end) begin
                clear_record();
                if (skip_rest) phase = TOK_SKIP;
            end else begin
                if (field_no + 1 >= MAX_FIELDS) overflow = 1'b1;
                else field_no++;
                quoted = 1'b0;
                phase  = TOK_START;
            end
        endfunction

        function void after_close(logic [7:0] b);
            if (b == csvt_pkg::CH_CR || b == csvt_pkg::CH_LF) begin
                close_field(1'b1, 1'b1);
            end else if (b == csvt_pkg::CH_COMMA) begin
                close_field(1'b0, 1'b0);
            end else begin
                emit(csvt_pkg::KIND_ERROR, 8'h00, 1'b0);
                phase = TOK_ERROR;
            end
        endfunction

        function void take_text(logic [7:0] b);
            if (phase == TOK_START) begin
                phase = TOK_DATA;
                if (b == csvt_pkg::CH_QUOTE) begin
                    quoted = 1'b1;
                    return;
                end
                quoted = 1'b0;
            end
            case (phase)
                TOK_DATA: begin
                    if (quoted) begin
                        if (b == csvt_pkg::CH_QUOTE) phase = TOK_QUOTE;
                        else emit(csvt_pkg::KIND_DATA, b, 1'b0);
                    end else if (b == csvt_pkg::CH_COMMA) begin
                        close_field(1'b0, 1'b0);
                    end else if (b == csvt_pkg::CH_CR || b == csvt_pkg::CH_LF) begin
                        close_field(1'b1, 1'b1);
                    end else begin
                        emit(csvt_pkg::KIND_DATA, b, 1'b0);
                    end
                end
                TOK_QUOTE: begin
                    if (b == csvt_pkg::CH_QUOTE) begin
                        phase = TOK_DATA;
                        emit(csvt_pkg::KIND_DATA, b, 1'b0);
                    end else begin
                        phase = TOK_DELIM;
                        after_close(b);
                    end
                end
                TOK_DELIM: after_close(b);
                default: ;
            endcase
        endfunction

        function void note_word(logic [1:0] mode, logic [7:0] b);
            case (mode)
                csvt_pkg::MODE_TEXT: take_text(b);
                csvt_pkg::MODE_CHUNK: begin
                    case (phase)
                        TOK_START, TOK_QUOTE, TOK_DELIM: close_field(1'b1, 1'b0);
                        TOK_DATA: if (!quoted) close_field(1'b1, 1'b0);
                        TOK_SKIP: clear_record();
                        default: ;
                    endcase
                end
                csvt_pkg::MODE_EOI: begin
                    case (phase)
                        TOK_START: if (field_no != 0 || overflow) close_field(1'b1, 1'b0);
                        TOK_DATA: begin
                            if (quoted) emit(csvt_pkg::KIND_ERROR, 8'h00, 1'b0);
                            else close_field(1'b1, 1'b0);
                        end
                        TOK_QUOTE, TOK_DELIM: close_field(1'b1, 1'b0);
                        default: ;
                    endcase
                    clear_record();
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] ch, logic [4:0] index,
                                   logic rec_end, logic tmf);
            token_result_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected result word: kind %0d char %0h", kind, ch);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, kind);
                mismatches++;
            end
            if (ch !== want.ch) begin
                $error("char_out: expected %0h, actual %0h", want.ch, ch);
                mismatches++;
            end
            if (index !== want.index) begin
                $error("field_index: expected %0d, actual %0d", want.index, index);
                mismatches++;
            end
            if (rec_end !== want.rec_end) begin
                $error("record_end: expected %0b, actual %0b", want.rec_end, rec_end);
                mismatches++;
            end
            if (tmf !== want.overflow) begin
                $error("too_many_fields: expected %0b, actual %0b", want.overflow, tmf);
                mismatches++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode      = csvt_pkg::MODE_TEXT;
    logic [7:0] s_data_byte = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [1:0] m_kind;
    logic [7:0] m_char_out;
    logic [4:0] m_field_index;
    logic       m_record_end;
    logic       m_too_many_fields;

    csv_token_board board;
    int unsigned    words_sent  = 0;
    int unsigned    quiet_count = 0;
    bit             tx_idle_on  = 1'b1;
    bit             rx_idle_on  = 1'b1;

    csv_field_tokenizer #(
        .MAX_FIELDS(MAX_FIELDS)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_char_out       (m_char_out),
        .m_field_index    (m_field_index),
        .m_record_end     (m_record_end),
        .m_too_many_fields(m_too_many_fields)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_word(s_mode, s_data_byte);
            if (m_valid && m_ready) begin
                board.check_result(m_kind, m_char_out, m_field_index, m_record_end,
                                   m_too_many_fields);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_count = 0;
            end else begin
                quiet_count++;
                if (quiet_count >= QUIET_LIMIT) begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_word(csvt_pkg::mode_t mode, logic [7:0] b);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_data_byte <= b;
        words_sent++;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] plain_byte(bit first);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == csvt_pkg::CH_COMMA || b == csvt_pkg::CH_CR || b == csvt_pkg::CH_LF ||
               (first && b == csvt_pkg::CH_QUOTE));
        return b;
    endfunction

    task automatic send_field(bit quoted, int unsigned len);
        logic [7:0] b;
        if (!quoted) begin
            for (int i = 0; i < len; i++) send_word(csvt_pkg::MODE_TEXT, plain_byte(i == 0));
        end else begin
            send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_QUOTE);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 5) == 0) begin
                    send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_QUOTE);
                    send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_QUOTE);
                end else begin
                    do b = 8'($urandom_range(0, 255)); while (b == csvt_pkg::CH_QUOTE);
                    send_word(csvt_pkg::MODE_TEXT, b);
                end
                if ($urandom_range(0, 15) == 0) begin
                    send_word(csvt_pkg::MODE_CHUNK, 8'($urandom_range(0, 255)));
                end
            end
            send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_QUOTE);
        end
    endtask

    task automatic send_record();
        int unsigned nf;
        int unsigned len_max;
        nf      = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 38) : $urandom_range(1, 5);
        len_max = (nf > 5) ? 1 : 6;
        for (int f = 0; f < nf; f++) begin
            if (f != 0) send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_COMMA);
            send_field($urandom_range(0, 2) == 0, $urandom_range(0, len_max));
        end
        case ($urandom_range(0, 7))
            0, 1, 2: begin
                send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_LF);
                send_word(csvt_pkg::MODE_CHUNK, 8'($urandom_range(0, 255)));
            end
            3: begin
                send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_CR);
                send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_LF);
                send_word(csvt_pkg::MODE_CHUNK, 8'($urandom_range(0, 255)));
            end
            4, 5: send_word(csvt_pkg::MODE_CHUNK, 8'($urandom_range(0, 255)));
            6: send_word(csvt_pkg::MODE_EOI, 8'($urandom_range(0, 255)));
            default: begin
                send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_CR);
                repeat ($urandom_range(0, 3)) begin
                    send_word(csvt_pkg::MODE_TEXT, 8'($urandom_range(0, 255)));
                end
                send_word(csvt_pkg::MODE_CHUNK, 8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic send_noise();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 0) begin
            send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_QUOTE);
            send_word(csvt_pkg::MODE_TEXT, plain_byte(1'b1));
            send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_QUOTE);
            do b = 8'($urandom_range(0, 255));
            while (b == csvt_pkg::CH_QUOTE || b == csvt_pkg::CH_COMMA ||
                   b == csvt_pkg::CH_CR || b == csvt_pkg::CH_LF);
            send_word(csvt_pkg::MODE_TEXT, b);
        end
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 5))
                0: b = csvt_pkg::CH_QUOTE;
                1: b = csvt_pkg::CH_COMMA;
                2: b = csvt_pkg::CH_CR;
                3: b = csvt_pkg::CH_LF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_word(csvt_pkg::mode_t'($urandom_range(0, 3)), b);
        end
        send_word(csvt_pkg::MODE_EOI, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        board = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        send_word(csvt_pkg::MODE_NONE, 8'hFF);
        send_word(csvt_pkg::MODE_EOI, 8'h00);
        send_word(csvt_pkg::MODE_CHUNK, 8'h00);
        send_word(csvt_pkg::MODE_TEXT, "a");
        send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_QUOTE);
        send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_COMMA);
        send_word(csvt_pkg::MODE_TEXT, 8'h00);
        send_word(csvt_pkg::MODE_TEXT, 8'hFF);
        send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_LF);
        send_word(csvt_pkg::MODE_TEXT, "z");
        send_word(csvt_pkg::MODE_CHUNK, 8'h00);
        send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_QUOTE);
        send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_COMMA);
        send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_CR);
        send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_QUOTE);
        send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_QUOTE);
        send_word(csvt_pkg::MODE_CHUNK, 8'h00);
        send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_QUOTE);
        send_word(csvt_pkg::MODE_CHUNK, 8'h00);
        send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_QUOTE);
        send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_QUOTE);
        send_word(csvt_pkg::MODE_TEXT, "x");
        send_word(csvt_pkg::MODE_CHUNK, 8'h00);
        send_word(csvt_pkg::MODE_EOI, 8'h00);
        send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_QUOTE);
        send_word(csvt_pkg::MODE_EOI, 8'h00);
        send_word(csvt_pkg::MODE_TEXT, "q");
        send_word(csvt_pkg::MODE_TEXT, csvt_pkg::CH_COMMA);
        send_word(csvt_pkg::MODE_EOI, 8'h00);

        while (words_sent < WORD_TARGET) begin
            tx_idle_on = (words_sent < CALM_START) && ($urandom_range(0, 4) != 0);
            rx_idle_on = (words_sent < CALM_START) && ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 7) == 0) send_noise();
            else send_record();
        end
        s_valid <= 1'b0;

        while (board.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
